>>> rtl/core/lss_pkg.sv
// Shared types, constants and helpers for the literal string substitution unit.
// Used by lss_cell, lss_out_buf and literal_string_substitution_unit.
`timescale 1ns / 1ps

package lss_pkg;

  // Default pattern depth and fixed field widths.
  localparam int unsigned MaxPattern = 8;
  localparam int unsigned CharW      = 8;
  localparam int unsigned RegW       = 64;
  localparam int unsigned LenW       = 4;
  localparam int unsigned AddrW      = 5;
  localparam int unsigned MaxRepl    = 8;

  // Register indexes on the configuration port (paddr[4:3]).
  localparam logic [1:0] REG_PATTERN_BYTES     = 2'd0;
  localparam logic [1:0] REG_PATTERN_LENGTH    = 2'd1;
  localparam logic [1:0] REG_REPLACEMENT_BYTES = 2'd2;
  localparam logic [1:0] REG_REPLACEMENT_LEN   = 2'd3;

  // One result item on its way to the output port.
  typedef struct packed {
    logic [CharW-1:0] chr;
    logic             present;
    logic             last;
  } lss_result_t;

  // Per-cycle command to one window cell.
  typedef struct packed {
    logic wr;
    logic shift;
  } lss_cell_ctrl_t;

  // Selects byte k of a 64-bit word, byte 0 in the lowest bits.
  function automatic logic [CharW-1:0] pick_byte(logic [RegW-1:0] word, logic [2:0] k);
    return word[{k, 3'b000} +: CharW];
  endfunction

endpackage

>>> rtl/core/lss_cell.sv
// One cell of the match window: holds one held byte and compares it with
// the pattern byte one place to its left. Depends on lss_pkg.
`timescale 1ns / 1ps

module lss_cell
  import lss_pkg::*;
(
  input  logic             clk_i,
  input  lss_cell_ctrl_t   ctrl_i,
  input  logic [CharW-1:0] din_i,
  input  logic [CharW-1:0] next_i,
  input  logic [CharW-1:0] pat_prev_i,
  output logic [CharW-1:0] byte_o,
  output logic             eq_prev_o
);

  logic [CharW-1:0] byte_q;

  // Load the incoming byte, or take the right-hand neighbour's byte on a shift.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr) begin
      byte_q <= din_i;
    end else if (ctrl_i.shift) begin
      byte_q <= next_i;
    end
  end

  // After a shift this byte sits one place further left in the window.
  assign eq_prev_o = (byte_q == pat_prev_i);
  assign byte_o    = byte_q;

endmodule

>>> rtl/core/lss_out_buf.sv
// Two-entry output buffer that decouples the result stream from the sequencer.
// Depends on lss_pkg for the result type.
`timescale 1ns / 1ps

module lss_out_buf
  import lss_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  lss_result_t data_i,
  output logic        space_o,
  output logic        valid_o,
  input  logic        ready_i,
  output lss_result_t data_o
);

  logic [1:0]  cnt_q, cnt_d;
  lss_result_t slot0_q, slot0_d;
  lss_result_t slot1_q, slot1_d;
  logic        pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = (cnt_q != 2'd0);
  assign space_o = (cnt_q != 2'd2);
  assign data_o  = slot0_q;

  // Slot 0 is always the head; slot 1 only fills while the head is stalled.
  always_comb begin
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    if (pop) begin
      slot0_d = (cnt_q == 2'd2) ? slot1_q : data_i;
      slot1_d = data_i;
    end else if (push_i) begin
      if (cnt_q == 2'd0) begin
        slot0_d = data_i;
      end else begin
        slot1_d = data_i;
      end
    end
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop};
  end

  // Occupancy count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Payload slots.
  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

endmodule

>>> rtl/core/literal_string_substitution_unit.sv
// Channel  | Direction | Signals                              | Contents
// s_axis   | in        | tvalid tready tdata tuser tlast      | text byte, byte flag, line end
// m_axis   | out       | tvalid tready tdata tuser tlast      | result byte, byte flag, line end
// apb      | in        | psel penable pwrite paddr pwdata ... | pattern and replacement setup
//
// An item with at most one result does not hold the input, so plain text flows at one byte
// per cycle while the output buffer has room. An item with n results holds the input until
// the rest are out, as the sequencer hands one result a cycle to the buffer while it has room.
// Reset clears the configuration, the fill count and the output buffer; the window cells
// are not reset. A stalled output absorbs one further result in the two-entry buffer.
// Top level of the literal string substitution unit. Depends on lss_pkg, lss_cell
// and lss_out_buf.
`timescale 1ns / 1ps

module literal_string_substitution_unit
  import lss_pkg::*;
#(
  parameter int unsigned MAX_PATTERN = MaxPattern
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // Input stream
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [7:0]       s_axis_tdata,   // [7:0] in_char
  input  logic             s_axis_tuser,   // [0] char_present
  input  logic             s_axis_tlast,
  // Output stream
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [7:0] out_char
  output logic             m_axis_tuser,   // [0] out_present
  output logic             m_axis_tlast,
  // Configuration port
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [RegW-1:0]  pwdata,
  output logic [RegW-1:0]  prdata,
  output logic             pready
);

  localparam int unsigned FillW = $clog2(MAX_PATTERN + 1);

  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_POP   = 2'd1;
  localparam logic [1:0] MODE_FLUSH = 2'd2;
  localparam logic [1:0] MODE_REPL  = 2'd3;

  // Configuration registers
  logic [RegW-1:0] pat_q, rep_q;
  logic [LenW-1:0] plen_q, rlen_q;
  logic            cfg_wr;
  logic [1:0]      cfg_idx;
  logic            pat_change;

  // Sequencer state
  logic [1:0]       mode_q, mode_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic [LenW-1:0]  rix_q, rix_d;
  logic             done_q, done_d;

  // Datapath
  logic [CharW-1:0]      cell_byte [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] eq_prev;
  lss_cell_ctrl_t        cell_ctrl [MAX_PATTERN];
  logic [CharW-1:0]      head;
  logic [LenW-1:0]       plen_eff, rlen_eff;
  logic [FillW-1:0]      fill_inc, fill_dec;
  logic                  prefix_ok, hit, full, post_hit;
  logic                  in_fire, shift_all, wr_en;
  logic [FillW-1:0]      wr_pos;
  logic                  push, buf_space;
  lss_result_t           push_data, out_data;
  logic [LenW-1:0]       rix_inc;

  // Configuration port: writes land on the access phase, reads are plain muxes.
  assign pready     = 1'b1;
  assign cfg_wr     = psel && penable && pwrite && pready;
  assign cfg_idx    = paddr[4:3];
  assign pat_change = cfg_wr &&
                      (cfg_idx == REG_PATTERN_BYTES || cfg_idx == REG_PATTERN_LENGTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q  <= '0;
      plen_q <= '0;
      rep_q  <= '0;
      rlen_q <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_PATTERN_BYTES:     pat_q  <= pwdata;
        REG_PATTERN_LENGTH:    plen_q <= pwdata[LenW-1:0];
        REG_REPLACEMENT_BYTES: rep_q  <= pwdata;
        REG_REPLACEMENT_LEN:   rlen_q <= pwdata[LenW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_PATTERN_BYTES:     prdata = pat_q;
      REG_PATTERN_LENGTH:    prdata = {{(RegW-LenW){1'b0}}, plen_q};
      REG_REPLACEMENT_BYTES: prdata = rep_q;
      REG_REPLACEMENT_LEN:   prdata = {{(RegW-LenW){1'b0}}, rlen_q};
      default:               prdata = '0;
    endcase
  end

  // Effective lengths, clamped to the window depth and the replacement width.
  assign plen_eff = (plen_q > LenW'(MAX_PATTERN)) ? LenW'(MAX_PATTERN) : plen_q;
  assign rlen_eff = (rlen_q > LenW'(MaxRepl)) ? LenW'(MaxRepl) : rlen_q;

  // Row of window cells; cell 0 is the oldest held byte.
  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    logic [CharW-1:0] next_byte;
    logic [CharW-1:0] pat_prev;

    if (k == MAX_PATTERN - 1) begin : g_end
      assign next_byte = '0;
    end else begin : g_mid
      assign next_byte = cell_byte[k+1];
    end
    assign pat_prev = pick_byte(pat_q, 3'((k == 0) ? 0 : k - 1));

    assign cell_ctrl[k].wr    = wr_en && (wr_pos == FillW'(k));
    assign cell_ctrl[k].shift = shift_all;

    lss_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (cell_ctrl[k]),
      .din_i      (s_axis_tdata),
      .next_i     (next_byte),
      .pat_prev_i (pat_prev),
      .byte_o     (cell_byte[k]),
      .eq_prev_o  (eq_prev[k])
    );
  end

  assign head = cell_byte[0];

  // True when the held bytes after dropping the head still form a pattern prefix.
  always_comb begin
    prefix_ok = 1'b1;
    for (int k = 1; k < MAX_PATTERN; k++) begin
      if (FillW'(k) < fill_q && !eq_prev[k]) begin
        prefix_ok = 1'b0;
      end
    end
  end

  assign fill_inc = fill_q + 1'b1;
  assign fill_dec = fill_q - 1'b1;
  assign hit      = (s_axis_tdata == pick_byte(pat_q, 3'(fill_q)));
  assign post_hit = (s_axis_tdata == pick_byte(pat_q, 3'(fill_dec)));
  assign full     = (LenW'(fill_inc) == plen_eff);
  assign rix_inc  = rix_q + 1'b1;

  assign s_axis_tready = (mode_q == MODE_IDLE) && buf_space;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // Sequencer: decides each cycle what the window does and which result leaves.
  always_comb begin
    mode_d    = mode_q;
    fill_d    = fill_q;
    rix_d     = rix_q;
    done_d    = done_q;
    push      = 1'b0;
    push_data = '0;
    shift_all = 1'b0;
    wr_en     = 1'b0;
    wr_pos    = fill_q;

    case (mode_q)
      MODE_IDLE: begin
        if (in_fire) begin
          if (s_axis_tuser && plen_eff == '0) begin
            // Substitution off: the byte passes straight through.
            push      = 1'b1;
            push_data = '{chr: s_axis_tdata, present: 1'b1, last: s_axis_tlast};
          end else if (s_axis_tuser && hit && full) begin
            // Whole pattern matched: start the replacement.
            fill_d = '0;
            if (rlen_eff != '0) begin
              push      = 1'b1;
              push_data = '{chr: pick_byte(rep_q, 3'd0), present: 1'b1,
                            last: s_axis_tlast && (rlen_eff == LenW'(1))};
              if (rlen_eff > LenW'(1)) begin
                mode_d = MODE_REPL;
                rix_d  = LenW'(1);
                done_d = s_axis_tlast;
              end
            end else if (s_axis_tlast) begin
              push      = 1'b1;
              push_data = '{chr: '0, present: 1'b0, last: 1'b1};
            end
          end else if (s_axis_tuser && hit && !s_axis_tlast) begin
            // Partial match grows: hold the byte.
            wr_en  = 1'b1;
            wr_pos = fill_q;
            fill_d = fill_inc;
          end else if (s_axis_tuser) begin
            // Release the oldest byte and append the new one in the same step; an empty window passes it on.
            push      = 1'b1;
            push_data = '{chr: (fill_q != '0) ? head : s_axis_tdata, present: 1'b1,
                          last: s_axis_tlast && (fill_q == '0)};
            shift_all = 1'b1;
            wr_en     = (fill_q != '0);
            wr_pos    = fill_dec;
            if (fill_q != '0) begin
              if (s_axis_tlast) begin
                mode_d = MODE_FLUSH;
              end else if (!(prefix_ok && post_hit)) begin
                mode_d = MODE_POP;
              end
            end
          end else if (s_axis_tlast) begin
            // Bare end mark: flush held bytes, or send the mark alone.
            push = 1'b1;
            if (fill_q == '0) begin
              push_data = '{chr: '0, present: 1'b0, last: 1'b1};
            end else begin
              push_data = '{chr: head, present: 1'b1, last: (fill_q == FillW'(1))};
              shift_all = 1'b1;
              fill_d    = fill_dec;
              if (fill_q > FillW'(1)) begin
                mode_d = MODE_FLUSH;
              end
            end
          end
        end
      end
      MODE_POP: begin
        if (buf_space) begin
          push      = 1'b1;
          push_data = '{chr: head, present: 1'b1, last: 1'b0};
          shift_all = 1'b1;
          fill_d    = fill_dec;
          if (!(fill_q > FillW'(1) && !prefix_ok)) begin
            mode_d = MODE_IDLE;
          end
        end
      end
      MODE_FLUSH: begin
        if (buf_space) begin
          push      = 1'b1;
          push_data = '{chr: head, present: 1'b1, last: (fill_q == FillW'(1))};
          shift_all = 1'b1;
          fill_d    = fill_dec;
          if (fill_q == FillW'(1)) begin
            mode_d = MODE_IDLE;
          end
        end
      end
      MODE_REPL: begin
        if (buf_space) begin
          push      = 1'b1;
          push_data = '{chr: pick_byte(rep_q, 3'(rix_q)), present: 1'b1,
                        last: done_q && (rix_inc == rlen_eff)};
          rix_d     = rix_inc;
          if (rix_inc == rlen_eff) begin
            mode_d = MODE_IDLE;
          end
        end
      end
      default: begin
        mode_d = MODE_IDLE;
      end
    endcase

    // A new pattern empties the window and abandons any release in progress.
    if (pat_change) begin
      fill_d = '0;
      if (mode_d == MODE_POP || mode_d == MODE_FLUSH) begin
        mode_d = MODE_IDLE;
      end
    end
  end

  // Sequencer control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      fill_q <= '0;
      rix_q  <= '0;
      done_q <= 1'b0;
    end else begin
      mode_q <= mode_d;
      fill_q <= fill_d;
      rix_q  <= rix_d;
      done_q <= done_d;
    end
  end

  // Output buffer and port mapping.
  lss_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .space_o (buf_space),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (out_data)
  );

  assign m_axis_tdata = out_data.chr;
  assign m_axis_tuser = out_data.present;
  assign m_axis_tlast = out_data.last;

  // The window only ever holds a proper prefix of the pattern.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q == '0 || LenW'(fill_q) < plen_eff)
    else $error("window fill reached the pattern length");

  // Replacement output only runs with an empty window.
  a_repl_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MODE_REPL |-> fill_q == '0)
    else $error("replacement started with held bytes");

  // Releasing or flushing always has a byte to send.
  a_release_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_POP || mode_q == MODE_FLUSH) |-> fill_q != '0)
    else $error("release with an empty window");

  // The end of a line leaves nothing held.
  a_line_end_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && push_data.last) |=> fill_q == '0)
    else $error("bytes still held after the end of a line");

  // Results are only produced when the output buffer has room.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> buf_space)
    else $error("result pushed into a full output buffer");

endmodule
